>>> hw/rtl/urf_pkg.sv
`timescale 1ns / 1ps
package urf_pkg;

    typedef enum logic [2:0] {
        CLS_UNDECIDED,
        CLS_ETH_HI,
        CLS_ARP,
        CLS_IPV4,
        CLS_UDP,
        CLS_DROP
    } t_class;

    localparam logic KIND_UDP = 1'b0;
    localparam logic KIND_ARP = 1'b1;

    localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
    localparam logic [1:0] REG_LOCAL_MAC   = 2'd1;
    localparam logic [1:0] REG_LISTEN_PORT = 2'd2;

    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] ARPOP_REQ  = 16'd1;
    localparam logic [15:0] ARPOP_REP  = 16'd2;

    localparam int HEADER_BYTES    = 42;
    localparam int ARP_FRAME_BYTES = 42;
    localparam int ARP_STORE_DEPTH = 22;
    localparam int QDEPTH          = 4;
    localparam int QAW             = 2;

    // one queue word: payload byte, or reply command when kind is arp
    typedef struct packed {
        logic [7:0]  data;
        logic        kind;
        logic        last;
        logic [31:0] ip;
        logic [15:0] port;
    } t_entry;

endpackage

>>> hw/rtl/urf_front.sv
`timescale 1ns / 1ps
module urf_front #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_last,
    input  logic [10:0]       i_buffer_limit,
    input  logic [31:0]       i_local_ip,
    input  logic [15:0]       i_listen_port,
    input  logic              i_full,
    output logic              o_push,
    output urf_pkg::t_entry   o_entry,
    output logic [7:0]        o_snap [urf_pkg::ARP_STORE_DEPTH],
    input  logic              i_arp_done
);
    localparam int OFF_W = $clog2(MAX_FRAME_BYTES);

    logic [OFF_W-1:0]  r_off;
    urf_pkg::t_class   r_class, n_class;
    logic [7:0]        r_store [urf_pkg::ARP_STORE_DEPTH];
    logic [31:0]       r_sip, n_sip;
    logic [15:0]       r_sport, n_sport;
    logic [10:0]       r_cnt, n_cnt;
    logic [10:0]       r_lim;
    logic              r_arp_busy;
    logic              accept;
    logic              arp_fire;
    logic [OFF_W-1:0]  d6, d8, d10;
    logic [10:0]       cnt_inc;
    logic [7:0]        ip_want;
    logic [7:0]        port_want;

    assign o_rx_ready = !i_full && !(r_arp_busy && i_rx_last);
    assign accept     = i_rx_valid && o_rx_ready;
    assign d6  = r_off - OFF_W'(6);
    assign d8  = r_off - OFF_W'(8);
    assign d10 = r_off - OFF_W'(10);
    assign cnt_inc = r_cnt + 11'd1;
    assign ip_want = (r_off == OFF_W'(38)) ? i_local_ip[31:24] :
                     (r_off == OFF_W'(39)) ? i_local_ip[23:16] :
                     (r_off == OFF_W'(40)) ? i_local_ip[15:8]  : i_local_ip[7:0];
    assign port_want = (r_off == OFF_W'(36)) ? i_listen_port[15:8] : i_listen_port[7:0];

    always_comb begin
        n_class = r_class;
        n_sip   = r_sip;
        n_sport = r_sport;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_entry = '0;
        if (r_off == OFF_W'(12)) begin
            n_class = (i_rx_byte == urf_pkg::ETYPE_ARP[15:8]) ? urf_pkg::CLS_ETH_HI
                                                              : urf_pkg::CLS_DROP;
        end else if (r_off == OFF_W'(13)) begin
            if (r_class == urf_pkg::CLS_ETH_HI) begin
                if (i_rx_byte == urf_pkg::ETYPE_ARP[7:0]) begin
                    n_class = urf_pkg::CLS_ARP;
                end else if (i_rx_byte == urf_pkg::ETYPE_IPV4[7:0]) begin
                    n_class = urf_pkg::CLS_IPV4;
                end else begin
                    n_class = urf_pkg::CLS_DROP;
                end
            end
        end else if (r_class == urf_pkg::CLS_ARP) begin
            if (r_off == OFF_W'(20) && i_rx_byte != urf_pkg::ARPOP_REQ[15:8]) begin
                n_class = urf_pkg::CLS_DROP;
            end else if (r_off == OFF_W'(21) && i_rx_byte != urf_pkg::ARPOP_REQ[7:0]) begin
                n_class = urf_pkg::CLS_DROP;
            end else if (r_off >= OFF_W'(38) && r_off <= OFF_W'(41)
                         && i_rx_byte != ip_want) begin
                n_class = urf_pkg::CLS_DROP;
            end
        end else if (r_class == urf_pkg::CLS_IPV4) begin
            if (r_off == OFF_W'(23)) begin
                n_class = (i_rx_byte == urf_pkg::PROTO_UDP) ? urf_pkg::CLS_UDP
                                                            : urf_pkg::CLS_DROP;
            end
        end else if (r_class == urf_pkg::CLS_UDP) begin
            if (r_off >= OFF_W'(26) && r_off <= OFF_W'(29)) begin
                n_sip = {r_sip[23:0], i_rx_byte};
            end else if (r_off == OFF_W'(34) || r_off == OFF_W'(35)) begin
                n_sport = {r_sport[7:0], i_rx_byte};
            end else if (r_off == OFF_W'(36) || r_off == OFF_W'(37)) begin
                if (i_listen_port != 16'd0 && i_rx_byte != port_want) begin
                    n_class = urf_pkg::CLS_DROP;
                end
            end else if (r_off >= OFF_W'(urf_pkg::HEADER_BYTES) && r_cnt < r_lim) begin
                n_cnt        = cnt_inc;
                o_push       = accept;
                o_entry.data = i_rx_byte;
                o_entry.kind = urf_pkg::KIND_UDP;
                o_entry.last = i_rx_last || (cnt_inc == r_lim);
                o_entry.ip   = o_entry.last ? r_sip : 32'd0;
                o_entry.port = o_entry.last ? r_sport : 16'd0;
            end
        end
        arp_fire = 1'b0;
        if (i_rx_last && n_class == urf_pkg::CLS_ARP
            && r_off >= OFF_W'(urf_pkg::ARP_FRAME_BYTES - 1)) begin
            arp_fire     = accept;
            o_push       = accept;
            o_entry      = '0;
            o_entry.kind = urf_pkg::KIND_ARP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off      <= '0;
            r_class    <= urf_pkg::CLS_UNDECIDED;
            r_sip      <= '0;
            r_sport    <= '0;
            r_cnt      <= '0;
            r_lim      <= '0;
            r_arp_busy <= 1'b0;
        end else begin
            if (i_arp_done) begin
                r_arp_busy <= 1'b0;
            end
            if (accept) begin
                if (r_off == '0) begin
                    r_lim <= i_buffer_limit;
                end
                r_sip   <= n_sip;
                r_sport <= n_sport;
                if (arp_fire) begin
                    r_arp_busy <= 1'b1;
                end
                if (i_rx_last) begin
                    r_off   <= '0;
                    r_class <= urf_pkg::CLS_UNDECIDED;
                    r_cnt   <= '0;
                end else begin
                    r_class <= n_class;
                    r_cnt   <= n_cnt;
                    if (r_off < OFF_W'(MAX_FRAME_BYTES - 1)) begin
                        r_off <= r_off + OFF_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_off >= OFF_W'(6) && r_off <= OFF_W'(11)) begin
                r_store[d6[4:0]] <= i_rx_byte;
            end else if (r_off >= OFF_W'(14) && r_off <= OFF_W'(19)) begin
                r_store[d8[4:0]] <= i_rx_byte;
            end else if (r_off >= OFF_W'(22) && r_off <= OFF_W'(31)) begin
                r_store[d10[4:0]] <= i_rx_byte;
            end
        end
        if (arp_fire) begin
            o_snap <= r_store;
        end
    end

endmodule

>>> hw/rtl/urf_queue.sv
`timescale 1ns / 1ps
module urf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  urf_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output urf_pkg::t_entry o_head
);
    urf_pkg::t_entry          r_mem [urf_pkg::QDEPTH];
    logic [urf_pkg::QAW-1:0]  r_wp, r_rp;
    logic [urf_pkg::QAW:0]    r_cnt;

    assign o_full  = (r_cnt == (urf_pkg::QAW+1)'(urf_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/urf_back.sv
`timescale 1ns / 1ps
module urf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  urf_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_arp_done,
    input  logic [7:0]      i_snap [urf_pkg::ARP_STORE_DEPTH],
    input  logic [47:0]     i_local_mac,
    input  logic [31:0]     i_local_ip,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_kind,
    output logic            o_out_last,
    output logic [31:0]     o_peer_ip,
    output logic [15:0]     o_peer_port
);
    logic [5:0] r_idx;
    logic [7:0] arp_byte;
    logic [2:0] mi;
    logic       adv;
    logic       arp_end;

    always_comb begin
        mi       = 3'd0;
        arp_byte = 8'd0;
        if (r_idx < 6'd6) begin
            arp_byte = i_snap[5'(r_idx)];
        end else if (r_idx < 6'd12) begin
            mi       = 3'(r_idx - 6'd6);
            arp_byte = i_local_mac[8*(5-mi) +: 8];
        end else if (r_idx == 6'd12) begin
            arp_byte = urf_pkg::ETYPE_ARP[15:8];
        end else if (r_idx == 6'd13) begin
            arp_byte = urf_pkg::ETYPE_ARP[7:0];
        end else if (r_idx < 6'd20) begin
            arp_byte = i_snap[5'(r_idx - 6'd8)];
        end else if (r_idx == 6'd20) begin
            arp_byte = urf_pkg::ARPOP_REP[15:8];
        end else if (r_idx == 6'd21) begin
            arp_byte = urf_pkg::ARPOP_REP[7:0];
        end else if (r_idx < 6'd28) begin
            mi       = 3'(r_idx - 6'd22);
            arp_byte = i_local_mac[8*(5-mi) +: 8];
        end else if (r_idx < 6'd32) begin
            mi       = 3'(r_idx - 6'd28);
            arp_byte = i_local_ip[8*(3-mi) +: 8];
        end else begin
            arp_byte = i_snap[5'(r_idx - 6'd20)];
        end
    end

    assign adv        = !o_out_valid || i_out_ready;
    assign arp_end    = (r_idx == 6'(urf_pkg::ARP_FRAME_BYTES - 1));
    assign o_pop      = adv && !i_empty
                        && (i_head.kind == urf_pkg::KIND_UDP || arp_end);
    assign o_arp_done = o_pop && i_head.kind == urf_pkg::KIND_ARP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (adv) begin
            o_out_valid <= !i_empty;
            if (!i_empty && i_head.kind == urf_pkg::KIND_ARP) begin
                r_idx <= arp_end ? 6'd0 : r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && !i_empty) begin
            if (i_head.kind == urf_pkg::KIND_ARP) begin
                o_out_byte  <= arp_byte;
                o_out_kind  <= urf_pkg::KIND_ARP;
                o_out_last  <= arp_end;
                o_peer_ip   <= 32'd0;
                o_peer_port <= 16'd0;
            end else begin
                o_out_byte  <= i_head.data;
                o_out_kind  <= urf_pkg::KIND_UDP;
                o_out_last  <= i_head.last;
                o_peer_ip   <= i_head.ip;
                o_peer_port <= i_head.port;
            end
        end
    end

endmodule

>>> hw/rtl/udp_rx_filter_arp_responder.sv
`timescale 1ns / 1ps
// channel | valid       | ready       | word
// rx      | i_rx_valid  | o_rx_ready  | i_rx_byte, i_rx_last, i_buffer_limit
// out     | o_out_valid | i_out_ready | o_out_byte, o_out_kind, o_out_last,
//         |             |             | o_peer_ip, o_peer_port
// cfg     | i_cfg_we    | none        | i_cfg_idx, i_cfg_data
// one rx word per cycle while o_rx_ready is high; payload words pass through the queue, then the output register
// an arp reply leaves as 42 words, one per cycle while i_out_ready is high, from the output stage
// a 4-word queue sits between classifier and output stage
// rx stalls on a full queue, or on a frame's last word while a reply still drains
// reset is synchronous; config registers come up at their reset values
module udp_rx_filter_arp_responder #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_last,
    input  logic [10:0] i_buffer_limit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_kind,
    output logic        o_out_last,
    output logic [31:0] o_peer_ip,
    output logic [15:0] o_peer_port
);
    logic [31:0]     r_local_ip;
    logic [47:0]     r_local_mac;
    logic [15:0]     r_listen_port;
    logic            push, pop, full, empty, arp_done;
    urf_pkg::t_entry entry, head;
    logic [7:0]      snap [urf_pkg::ARP_STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= 32'hC0A8_0101;
            r_local_mac   <= '0;
            r_listen_port <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                urf_pkg::REG_LOCAL_IP:    r_local_ip    <= i_cfg_data[31:0];
                urf_pkg::REG_LOCAL_MAC:   r_local_mac   <= i_cfg_data;
                urf_pkg::REG_LISTEN_PORT: r_listen_port <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    urf_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
        .i_clk, .i_rst_n,
        .i_rx_valid, .o_rx_ready, .i_rx_byte, .i_rx_last, .i_buffer_limit,
        .i_local_ip(r_local_ip), .i_listen_port(r_listen_port),
        .i_full(full), .o_push(push), .o_entry(entry),
        .o_snap(snap), .i_arp_done(arp_done)
    );

    urf_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_entry(entry), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_head(head)
    );

    urf_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(empty), .i_head(head), .o_pop(pop), .o_arp_done(arp_done),
        .i_snap(snap), .i_local_mac(r_local_mac), .i_local_ip(r_local_ip),
        .o_out_valid, .i_out_ready, .o_out_byte, .o_out_kind, .o_out_last,
        .o_peer_ip, .o_peer_port
    );

endmodule

>>> hw/rtl/urf_checker.sv
`timescale 1ns / 1ps
module urf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_out_kind,
    input logic        o_out_last,
    input logic [31:0] o_peer_ip,
    input logic [15:0] o_peer_port
);
    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");

    // peer fields only ride on the last payload word
    a_peer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !(o_out_last && o_out_kind == urf_pkg::KIND_UDP)
        |-> o_peer_ip == 32'd0 && o_peer_port == 16'd0)
        else $error("peer fields off the last payload word");

    // a reply word that is not last is followed by another reply word
    a_reply_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_kind == urf_pkg::KIND_ARP && !o_out_last
        |=> o_out_valid && o_out_kind == urf_pkg::KIND_ARP)
        else $error("arp reply broken up");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("stalled word changed");

endmodule

bind udp_rx_filter_arp_responder urf_checker u_urf_checker (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_ready, .o_out_byte,
    .o_out_kind, .o_out_last, .o_peer_ip, .o_peer_port
);
